>>> rtl/core/dpcsw_pkg.sv
// ============================================================================
// dpcsw_pkg
// Shared types and constants for the dual potentiometer change-driven
// serial writer.
// ============================================================================
`default_nettype none

package dpcsw_pkg;

    // Wiper value width and chip count.
    localparam int AMP_W      = 8;
    localparam int NUM_CHIPS  = 2;

    // One frame is a stack-select bit followed by two wiper bytes.
    localparam int FRAME_BITS = 1 + 2 * AMP_W;
    localparam int BIT_CNT_W  = $clog2(FRAME_BITS);
    localparam logic [BIT_CNT_W-1:0] LAST_BIT = BIT_CNT_W'(FRAME_BITS - 1);

    // Stack-select bit sent at the head of every frame.
    localparam logic STACK_SEL = 1'b0;

    // Chip select codes.
    localparam logic CHIP_FIRST  = 1'b0;
    localparam logic CHIP_SECOND = 1'b1;

    typedef logic [AMP_W-1:0]      amp_t;
    typedef logic [FRAME_BITS-1:0] frame_t;
    typedef logic [BIT_CNT_W-1:0]  bit_cnt_t;

    // Writer sequencer states.
    typedef enum logic
    {
        ST_IDLE,
        ST_SHIFT
    } dpcsw_state_t;

endpackage : dpcsw_pkg

`default_nettype wire

>>> rtl/core/dpcsw_if.sv
// ============================================================================
// dpcsw channel interfaces
// Valid/ready channels for the wiper value requests and the serial bit
// results.
// ============================================================================
`default_nettype none

interface dpcsw_amp_if;
    logic       valid;
    logic       ready;
    logic [7:0] amp_ch1;
    logic [7:0] amp_ch2;
    logic [7:0] amp_ch3;
    logic [7:0] amp_ch4;

    modport source (output valid, amp_ch1, amp_ch2, amp_ch3, amp_ch4, input ready);
    modport sink   (input valid, amp_ch1, amp_ch2, amp_ch3, amp_ch4, output ready);
endinterface : dpcsw_amp_if

interface dpcsw_bit_if;
    logic valid;
    logic ready;
    logic chip_index;
    logic serial_bit;
    logic frame_end;
    logic last;

    modport source (output valid, chip_index, serial_bit, frame_end, last, input ready);
    modport sink   (input valid, chip_index, serial_bit, frame_end, last, output ready);
endinterface : dpcsw_bit_if

`default_nettype wire

>>> rtl/core/dual_pot_change_serial_writer.sv
// The first serial bit is offered in the cycle after a request is accepted.
// A request sends 0, 17 or 34 bits, one bit per cycle while the receiver is
// ready, through a 17-bit frame shift register; a new request is accepted in
// the cycle after the last bit is taken.
// Reset: asynchronous, active low; all channels are marked unknown, so the
// first request after reset writes both chips.
// ============================================================================
// dual_pot_change_serial_writer
// Compares each request's four wiper values with the values last sent and
// shifts out a 17-bit frame for every chip whose values changed.
// ============================================================================
`default_nettype none

module dual_pot_change_serial_writer
(
    input  wire          clk,
    input  wire          rst_n,
    dpcsw_amp_if.sink    amp_req,
    dpcsw_bit_if.source  bit_req
);
    import dpcsw_pkg::*;

    dpcsw_state_t state_reg, state_next;

    amp_t     sent_reg [2*NUM_CHIPS];
    amp_t     sent_next [2*NUM_CHIPS];
    logic [NUM_CHIPS-1:0] known_reg, known_next;

    frame_t   frame_sr_reg, frame_sr_next;
    frame_t   pend_frame_reg, pend_frame_next;
    logic     pend_valid_reg, pend_valid_next;
    logic     chip_reg, chip_next;
    bit_cnt_t bit_cnt_reg, bit_cnt_next;

    logic     amp_fire;
    logic     bit_fire;
    logic     at_frame_end;
    logic     chg0;
    logic     chg1;
    frame_t   frame0;
    frame_t   frame1;

    assign amp_fire     = amp_req.valid && amp_req.ready;
    assign bit_fire     = bit_req.valid && bit_req.ready;
    assign at_frame_end = (bit_cnt_reg == LAST_BIT);

    // Change detection per chip against the values last sent.
    assign chg0 = !known_reg[0] || (sent_reg[0] != amp_req.amp_ch1)
                                || (sent_reg[1] != amp_req.amp_ch2);
    assign chg1 = !known_reg[1] || (sent_reg[2] != amp_req.amp_ch3)
                                || (sent_reg[3] != amp_req.amp_ch4);

    // Frames carry the second channel byte ahead of the first.
    assign frame0 = {STACK_SEL, amp_req.amp_ch2, amp_req.amp_ch1};
    assign frame1 = {STACK_SEL, amp_req.amp_ch4, amp_req.amp_ch3};

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (amp_fire && (chg0 || chg1))
                begin
                    state_next = ST_SHIFT;
                end
            end
            ST_SHIFT:
            begin
                if (bit_fire && at_frame_end && !pend_valid_reg)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Handshake and result outputs.
    always_comb
    begin
        amp_req.ready      = (state_reg == ST_IDLE);
        bit_req.valid      = (state_reg == ST_SHIFT);
        bit_req.chip_index = chip_reg;
        bit_req.serial_bit = frame_sr_reg[FRAME_BITS-1];
        bit_req.frame_end  = at_frame_end;
        bit_req.last       = at_frame_end && !pend_valid_reg;
    end

    // Datapath: stored values, frame shift register and bit counter.
    always_comb
    begin
        for (int i = 0; i < 2*NUM_CHIPS; i++)
        begin
            sent_next[i] = sent_reg[i];
        end
        known_next      = known_reg;
        frame_sr_next   = frame_sr_reg;
        pend_frame_next = pend_frame_reg;
        pend_valid_next = pend_valid_reg;
        chip_next       = chip_reg;
        bit_cnt_next    = bit_cnt_reg;

        if (amp_fire)
        begin
            // Capture the new values and queue the frames to send.
            sent_next[0]    = amp_req.amp_ch1;
            sent_next[1]    = amp_req.amp_ch2;
            sent_next[2]    = amp_req.amp_ch3;
            sent_next[3]    = amp_req.amp_ch4;
            known_next      = '1;
            bit_cnt_next    = '0;
            pend_frame_next = frame1;
            pend_valid_next = chg0 && chg1;
            if (chg0)
            begin
                frame_sr_next = frame0;
                chip_next     = CHIP_FIRST;
            end
            else
            begin
                frame_sr_next = frame1;
                chip_next     = CHIP_SECOND;
            end
        end
        else if (bit_fire)
        begin
            if (at_frame_end)
            begin
                // Move on to the queued second-chip frame, if any.
                bit_cnt_next = '0;
                if (pend_valid_reg)
                begin
                    frame_sr_next   = pend_frame_reg;
                    chip_next       = CHIP_SECOND;
                    pend_valid_next = 1'b0;
                end
            end
            else
            begin
                frame_sr_next = {frame_sr_reg[FRAME_BITS-2:0], 1'b0};
                bit_cnt_next  = bit_cnt_reg + 1'b1;
            end
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            known_reg      <= '0;
            pend_valid_reg <= 1'b0;
            bit_cnt_reg    <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            known_reg      <= known_next;
            pend_valid_reg <= pend_valid_next;
            bit_cnt_reg    <= bit_cnt_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 2*NUM_CHIPS; i++)
        begin
            sent_reg[i] <= sent_next[i];
        end
        frame_sr_reg   <= frame_sr_next;
        pend_frame_reg <= pend_frame_next;
        chip_reg       <= chip_next;
    end

    // A queued frame only waits behind a first-chip frame.
    a_pend_first_chip: assert property (@(posedge clk) disable iff (!rst_n)
        (bit_req.valid && pend_valid_reg) |-> (chip_reg == CHIP_FIRST))
        else $error("queued frame behind a second-chip frame");

    // After the final bit of a request the block takes new requests.
    a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
        (bit_fire && bit_req.last) |=> (amp_req.ready && !bit_req.valid))
        else $error("block did not return to idle after the final bit");

    // A frame end that is not the final bit starts the second chip's frame.
    a_second_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (bit_fire && bit_req.frame_end && !bit_req.last) |=>
        (bit_req.valid && (bit_req.chip_index == CHIP_SECOND) && (bit_cnt_reg == '0)))
        else $error("second frame did not follow the first");

    // Every frame opens with the stack-select bit.
    a_stack_sel: assert property (@(posedge clk) disable iff (!rst_n)
        (bit_req.valid && (bit_cnt_reg == '0)) |-> (bit_req.serial_bit == STACK_SEL))
        else $error("frame did not start with the stack-select bit");

    // An accepted request leaves every channel known.
    a_known_after: assert property (@(posedge clk) disable iff (!rst_n)
        amp_fire |=> (known_reg == '1))
        else $error("channels not marked known after a request");

endmodule : dual_pot_change_serial_writer

`default_nettype wire
